// ===== rtl/hcbu_pkg.sv =====
// hcbu_pkg: types, constants and the magic-header lookup shared by the
// block unpermuter modules. No dependencies.
package hcbu_pkg;

  localparam int IDX_W     = 6;                // index width of both stores
  localparam int MEM_DEPTH = 64;               // entries in each store
  localparam int POS_W     = 7;                // header or word byte count
  localparam int MAGIC_LEN = 28;
  localparam logic [MAGIC_LEN*8-1:0] MAGIC_TEXT = "jingxiaoshijiayoumyuiszhazha";

  typedef enum logic [2:0] {
    STS_DATA  = 3'd0,
    STS_DONE  = 3'd1,
    STS_HDR   = 3'd2,
    STS_SIZE  = 3'd3,
    STS_TRUNC = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_TABLE,
    PH_DATA,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_IDX,
    EM_BUF,
    EM_OUT,
    EM_STAT
  } emit_state_t;

  // Work handed from the input parser to the emitter.
  typedef struct packed {
    logic             start;
    logic             gather;   // 1: full block through the index table
    logic [IDX_W-1:0] len;      // data items to send
    logic             stat_vld;
    status_t          stat;
    logic             eof;
  } emit_req_t;

  // Header byte at a position; positions past the text compare with zero.
  function automatic logic [7:0] magic_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (int'(idx) < MAGIC_LEN)
      b = MAGIC_TEXT[8*(MAGIC_LEN-1-int'(idx)) +: 8];
    return b;
  endfunction

endpackage

// ===== rtl/hcbu_ram.sv =====
// hcbu_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hcbu_parse.sv =====
// hcbu_parse: per-byte file parser (header check, size and table words,
// block fill). Writes the index and block stores, hands work to hcbu_emit.
// Depends on hcbu_pkg.
module hcbu_parse #(
  parameter int MAX_BLOCK  = 63,
  parameter int HEADER_LEN = 28
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [7:0]                     in_byte,
  input  logic                           in_eof,
  input  logic                           busy,
  input  logic                           restart,
  output logic                           sidx_we,
  output logic [hcbu_pkg::IDX_W-1:0]     sidx_waddr,
  output logic [hcbu_pkg::IDX_W-1:0]     sidx_wdata,
  output logic                           buf_we,
  output logic [hcbu_pkg::IDX_W-1:0]     buf_waddr,
  output logic [7:0]                     buf_wdata,
  output logic [hcbu_pkg::MEM_DEPTH-1:0] written,
  output hcbu_pkg::emit_req_t            req
);

  localparam int IW = hcbu_pkg::IDX_W;
  localparam int PW = hcbu_pkg::POS_W;

  hcbu_pkg::phase_t              phase_r, phase_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [31:0]                   word_r, word_nxt;
  logic [IW-1:0]                 bsize_r, bsize_nxt;
  logic [hcbu_pkg::MEM_DEPTH-1:0] written_r, written_nxt;
  logic [IW-1:0]                 fill_r, fill_nxt;
  logic [IW-1:0]                 entry_r, entry_nxt;

  logic          acc;
  logic [31:0]   word_new;
  logic          word_done;
  logic          size_bad;
  logic          hdr_ok;
  logic          hdr_end;
  logic          tbl_ok;
  logic [IW-1:0] entry_inc;
  logic          entry_hit;
  logic [IW-1:0] fill_inc;
  logic          fill_hit;
  logic [PW-1:0] pos_inc;

  assign acc       = in_valid && !busy;
  assign word_new  = word_r | ({24'd0, in_byte} << {pos_r[1:0], 3'd0});
  assign word_done = (pos_r[1:0] == 2'd3);
  assign size_bad  = (word_new == 32'd0) || (word_new > 32'(MAX_BLOCK));
  assign hdr_ok    = (in_byte == hcbu_pkg::magic_byte(pos_r[IW-1:0]));
  assign pos_inc   = pos_r + PW'(1);
  assign hdr_end   = (pos_inc == PW'(HEADER_LEN));
  assign tbl_ok    = (word_new < {{(32-IW){1'b0}}, bsize_r});
  assign entry_inc = entry_r + IW'(1);
  assign entry_hit = (entry_inc == bsize_r);
  assign fill_inc  = fill_r + IW'(1);
  assign fill_hit  = (fill_inc == bsize_r);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    word_nxt    = word_r;
    bsize_nxt   = bsize_r;
    written_nxt = written_r;
    fill_nxt    = fill_r;
    entry_nxt   = entry_r;
    if (acc) begin
      case (phase_r)
        hcbu_pkg::PH_HEADER: begin
          if (!hdr_ok) begin
            phase_nxt = hcbu_pkg::PH_SKIP;
          end else if (hdr_end) begin
            phase_nxt = hcbu_pkg::PH_SIZE;
            pos_nxt   = '0;
            word_nxt  = '0;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        hcbu_pkg::PH_SIZE: begin
          word_nxt = word_new;
          pos_nxt  = pos_inc;
          if (word_done) begin
            if (size_bad) begin
              phase_nxt = hcbu_pkg::PH_SKIP;
            end else begin
              phase_nxt   = hcbu_pkg::PH_TABLE;
              bsize_nxt   = word_new[IW-1:0];
              written_nxt = '0;
              entry_nxt   = '0;
              pos_nxt     = '0;
              word_nxt    = '0;
            end
          end
        end
        hcbu_pkg::PH_TABLE: begin
          word_nxt = word_new;
          pos_nxt  = pos_inc;
          if (word_done) begin
            if (tbl_ok) begin
              written_nxt[word_new[IW-1:0]] = 1'b1;
            end
            entry_nxt = entry_inc;
            pos_nxt   = '0;
            word_nxt  = '0;
            if (entry_hit) begin
              phase_nxt = hcbu_pkg::PH_DATA;
              fill_nxt  = '0;
            end
          end
        end
        hcbu_pkg::PH_DATA: begin
          fill_nxt = fill_hit ? '0 : fill_inc;
        end
        default: begin
        end
      endcase
    end
    // end of file: back to the header phase once its results are out
    if (restart || (acc && in_eof && !req.start)) begin
      phase_nxt   = hcbu_pkg::PH_HEADER;
      pos_nxt     = '0;
      word_nxt    = '0;
      bsize_nxt   = '0;
      written_nxt = '0;
      fill_nxt    = '0;
      entry_nxt   = '0;
    end
  end

  // outputs: store writes and emitter request
  always_comb begin
    req          = '0;
    req.stat     = hcbu_pkg::STS_DONE;
    req.eof      = in_eof;
    sidx_we      = acc && (phase_r == hcbu_pkg::PH_TABLE) && word_done && tbl_ok;
    sidx_waddr   = word_new[IW-1:0];
    sidx_wdata   = entry_r;
    buf_we       = acc && (phase_r == hcbu_pkg::PH_DATA);
    buf_waddr    = fill_r;
    buf_wdata    = in_byte;
    case (phase_r)
      hcbu_pkg::PH_HEADER: begin
        if (!hdr_ok) begin
          req.stat_vld = 1'b1;
          req.stat     = hcbu_pkg::STS_HDR;
        end else if (in_eof) begin
          req.stat_vld = 1'b1;
          req.stat     = hcbu_pkg::STS_TRUNC;
        end
      end
      hcbu_pkg::PH_SIZE: begin
        if (word_done && size_bad) begin
          req.stat_vld = 1'b1;
          req.stat     = hcbu_pkg::STS_SIZE;
        end else if (in_eof) begin
          req.stat_vld = 1'b1;
          req.stat     = hcbu_pkg::STS_TRUNC;
        end
      end
      hcbu_pkg::PH_TABLE: begin
        if (in_eof) begin
          req.stat_vld = 1'b1;
          req.stat     = (word_done && entry_hit) ? hcbu_pkg::STS_DONE
                                                  : hcbu_pkg::STS_TRUNC;
        end
      end
      hcbu_pkg::PH_DATA: begin
        req.gather   = fill_hit;
        req.len      = fill_hit ? bsize_r : (in_eof ? fill_inc : '0);
        req.stat_vld = in_eof;
        req.stat     = hcbu_pkg::STS_DONE;
      end
      default: begin
      end
    endcase
    req.start = acc && ((req.len != '0) || req.stat_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= hcbu_pkg::PH_HEADER;
      pos_r     <= '0;
      word_r    <= '0;
      bsize_r   <= '0;
      written_r <= '0;
      fill_r    <= '0;
      entry_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      word_r    <= word_nxt;
      bsize_r   <= bsize_nxt;
      written_r <= written_nxt;
      fill_r    <= fill_nxt;
      entry_r   <= entry_nxt;
    end
  end

  assign written = written_r;

endmodule

// ===== rtl/hcbu_emit.sv =====
// hcbu_emit: block emitter. Reads the index store, then the block store,
// and drives the registered output item. Depends on hcbu_pkg.
module hcbu_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hcbu_pkg::emit_req_t            req,
  input  logic [hcbu_pkg::MEM_DEPTH-1:0] written,
  output logic [hcbu_pkg::IDX_W-1:0]     sidx_raddr,
  input  logic [hcbu_pkg::IDX_W-1:0]     sidx_rdata,
  output logic [hcbu_pkg::IDX_W-1:0]     buf_raddr,
  input  logic [7:0]                     buf_rdata,
  output logic                           busy,
  output logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic [2:0]                     out_status,
  output logic                           out_last
);

  localparam int IW = hcbu_pkg::IDX_W;

  hcbu_pkg::emit_state_t state_r, state_nxt;
  logic [IW-1:0]    p_r, p_nxt;
  logic [IW-1:0]    src_r, src_nxt;
  logic             gather_r, gather_nxt;
  logic [IW-1:0]    len_r, len_nxt;
  logic             stat_vld_r, stat_vld_nxt;
  hcbu_pkg::status_t stat_r, stat_nxt;
  logic             eof_r, eof_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  hcbu_pkg::status_t out_stat_r, out_stat_nxt;
  logic             out_last_r, out_last_nxt;

  logic          out_free;
  logic          last_data;
  logic [IW-1:0] src_sel;
  logic          finish;

  assign out_free  = !out_valid_r || out_ready;
  assign last_data = ({1'b0, p_r} + (IW+1)'(1)) == {1'b0, len_r};
  assign src_sel   = (gather_r && written[p_r]) ? sidx_rdata : p_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hcbu_pkg::EM_IDLE: begin
        if (req.start) begin
          state_nxt = (req.len != '0) ? hcbu_pkg::EM_IDX : hcbu_pkg::EM_STAT;
        end
      end
      hcbu_pkg::EM_IDX: state_nxt = hcbu_pkg::EM_BUF;
      hcbu_pkg::EM_BUF: state_nxt = hcbu_pkg::EM_OUT;
      hcbu_pkg::EM_OUT: begin
        if (out_free) begin
          if (!last_data) begin
            state_nxt = hcbu_pkg::EM_IDX;
          end else if (stat_vld_r) begin
            state_nxt = hcbu_pkg::EM_STAT;
          end else begin
            state_nxt = hcbu_pkg::EM_IDLE;
          end
        end
      end
      hcbu_pkg::EM_STAT: begin
        if (out_free) begin
          state_nxt = hcbu_pkg::EM_IDLE;
        end
      end
      default: state_nxt = hcbu_pkg::EM_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    p_nxt         = p_r;
    src_nxt       = src_r;
    gather_nxt    = gather_r;
    len_nxt       = len_r;
    stat_vld_nxt  = stat_vld_r;
    stat_nxt      = stat_r;
    eof_nxt       = eof_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    buf_raddr     = src_r;
    finish        = 1'b0;
    case (state_r)
      hcbu_pkg::EM_IDLE: begin
        if (req.start) begin
          p_nxt        = '0;
          gather_nxt   = req.gather;
          len_nxt      = req.len;
          stat_vld_nxt = req.stat_vld;
          stat_nxt     = req.stat;
          eof_nxt      = req.eof;
        end
      end
      hcbu_pkg::EM_BUF: begin
        buf_raddr = src_sel;
        src_nxt   = src_sel;
      end
      hcbu_pkg::EM_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = buf_rdata;
          out_stat_nxt  = hcbu_pkg::STS_DATA;
          out_last_nxt  = last_data && !stat_vld_r;
          p_nxt         = p_r + IW'(1);
          finish        = last_data && !stat_vld_r;
        end
      end
      hcbu_pkg::EM_STAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'd0;
          out_stat_nxt  = stat_r;
          out_last_nxt  = 1'b1;
          finish        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcbu_pkg::EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    src_r      <= src_nxt;
    gather_r   <= gather_nxt;
    len_r      <= len_nxt;
    stat_vld_r <= stat_vld_nxt;
    stat_r     <= stat_nxt;
    eof_r      <= eof_nxt;
    out_byte_r <= out_byte_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sidx_raddr = p_r;
  assign busy       = (state_r != hcbu_pkg::EM_IDLE);
  assign restart    = finish && eof_r;
  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_stat_r;
  assign out_last   = out_last_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == hcbu_pkg::EM_IDLE)
    else $error("emit request while emitter busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcbu_pkg::EM_OUT && !out_free) |=>
      (state_r == hcbu_pkg::EM_OUT && $stable(src_r) && $stable(p_r)))
    else $error("gather step lost while output stalled");

  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcbu_pkg::EM_STAT && out_free) |=> (out_valid_r && out_last_r))
    else $error("status item not marked last");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hcbu_pkg::EM_BUF |-> p_r < len_r)
    else $error("emit position past block length");
`endif

endmodule

// ===== rtl/header_checked_block_unpermuter_unit.sv =====
// header_checked_block_unpermuter_unit: top level of the block unpermuter.
// Depends on hcbu_pkg, hcbu_ram, hcbu_parse and hcbu_emit.
//
// Decodes a block-transposed file given one byte per input item: checks the
// magic header, reads the little-endian block size N and N table entries,
// then sends out each full N-byte block reordered through the table, a
// trailing partial block unchanged, and a status item. A byte that completes
// a block starts the emitter, which for each output byte reads the index
// RAM, then the block RAM, then loads the output register, where it can wait
// on out_tready, and then sends the status item if any; new input waits until
// that run has been handed to the output register. The output register lets
// the next input byte in while the last item still waits. Both stores are
// 64-entry RAMs with registered reads and need no clearing after reset.
module header_checked_block_unpermuter_unit #(
  parameter int MAX_BLOCK  = 63,
  parameter int HEADER_LEN = 28
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_file
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [2:0] status
  output logic       out_tlast   // last_of_run
);

  localparam int IW = hcbu_pkg::IDX_W;

  logic                           busy;
  logic                           restart;
  hcbu_pkg::emit_req_t            req;
  logic [hcbu_pkg::MEM_DEPTH-1:0] written;
  logic                           sidx_we;
  logic [IW-1:0]                  sidx_waddr;
  logic [IW-1:0]                  sidx_wdata;
  logic [IW-1:0]                  sidx_raddr;
  logic [IW-1:0]                  sidx_rdata;
  logic                           buf_we;
  logic [IW-1:0]                  buf_waddr;
  logic [7:0]                     buf_wdata;
  logic [IW-1:0]                  buf_raddr;
  logic [7:0]                     buf_rdata;

  assign in_tready = !busy;

  hcbu_parse #(
    .MAX_BLOCK  (MAX_BLOCK),
    .HEADER_LEN (HEADER_LEN)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_eof     (in_tlast),
    .busy       (busy),
    .restart    (restart),
    .sidx_we    (sidx_we),
    .sidx_waddr (sidx_waddr),
    .sidx_wdata (sidx_wdata),
    .buf_we     (buf_we),
    .buf_waddr  (buf_waddr),
    .buf_wdata  (buf_wdata),
    .written    (written),
    .req        (req)
  );

  hcbu_ram #(
    .WIDTH (IW),
    .DEPTH (hcbu_pkg::MEM_DEPTH)
  ) u_sidx_ram (
    .clk   (clk),
    .we    (sidx_we),
    .waddr (sidx_waddr),
    .wdata (sidx_wdata),
    .raddr (sidx_raddr),
    .rdata (sidx_rdata)
  );

  hcbu_ram #(
    .WIDTH (8),
    .DEPTH (hcbu_pkg::MEM_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  hcbu_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .written    (written),
    .sidx_raddr (sidx_raddr),
    .sidx_rdata (sidx_rdata),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (buf_rdata),
    .busy       (busy),
    .restart    (restart),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
